// ===== rtl/cau_pkg.sv =====
// cau_pkg: shared types, constants and helper functions of the complex arithmetic unit
// used by cau_front, cau_div_step, cau_back and complex_arith_unit_core
// no dependencies
package cau_pkg;

   // fixed point format of the operand and result parts
   localparam int FRAC_BITS = 8;
   localparam int PART_W    = 16;
   localparam int WIDE_W    = 2 * PART_W + 1;
   localparam int DEN_W     = 2 * PART_W;
   localparam int QUO_W     = PART_W;
   localparam int NUM_W     = 2 * PART_W + FRAC_BITS;
   localparam int CMP_W     = DEN_W + QUO_W;
   localparam int DIV_STEPS = QUO_W;

   localparam logic signed [PART_W-1:0] PART_MAX = 16'sh7FFF;
   localparam logic signed [PART_W-1:0] PART_MIN = 16'sh8000;
   localparam logic [QUO_W-1:0] POS_LIMIT = 16'h7FFF;
   localparam logic [QUO_W-1:0] NEG_LIMIT = 16'h8000;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

   // one lane of the restoring divider: partial remainder and quotient bits
   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             ovf;
   } div_lane_type;

   // word carried down the pipeline after the front stages
   typedef struct packed {
      logic                     is_div;
      logic                     den_zero;
      logic [DEN_W-1:0]         den;
      div_lane_type             lane_r;
      div_lane_type             lane_i;
      logic signed [PART_W-1:0] pre_real;
      logic signed [PART_W-1:0] pre_imag;
      logic                     pre_sat;
   } pipe_word_type;

   typedef struct packed {
      logic signed [PART_W-1:0] value;
      logic                     sat;
   } clip_type;

   // saturate a wide signed value to one result part
   function automatic clip_type clip_part(input logic signed [WIDE_W-1:0] x);
      clip_type c;
      if (x > WIDE_W'(PART_MAX)) begin
         c.value = PART_MAX;
         c.sat   = 1'b1;
      end else if (x < WIDE_W'(PART_MIN)) begin
         c.value = PART_MIN;
         c.sat   = 1'b1;
      end else begin
         c.value = x[PART_W-1:0];
         c.sat   = 1'b0;
      end
      return c;
   endfunction

   // set up a divider lane: sign, scaled magnitude and quotient overflow check
   function automatic div_lane_type lane_start(input logic signed [WIDE_W-1:0] num,
                                               input logic [DEN_W-1:0] den);
      div_lane_type     l;
      logic [WIDE_W-1:0] mag;
      mag   = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
      l.neg = num[WIDE_W-1];
      l.rem = NUM_W'(mag[DEN_W-1:0]) << FRAC_BITS;
      l.quo = '0;
      l.ovf = (CMP_W'(l.rem) >= (CMP_W'(den) << QUO_W));
      return l;
   endfunction

   // apply the sign to a finished quotient and saturate
   function automatic clip_type lane_finish(input div_lane_type l);
      clip_type c;
      if (l.ovf) begin
         c.value = l.neg ? PART_MIN : PART_MAX;
         c.sat   = 1'b1;
      end else if (!l.neg) begin
         if (l.quo > POS_LIMIT) begin
            c.value = PART_MAX;
            c.sat   = 1'b1;
         end else begin
            c.value = $signed(l.quo);
            c.sat   = 1'b0;
         end
      end else begin
         if (l.quo > NEG_LIMIT) begin
            c.value = PART_MIN;
            c.sat   = 1'b1;
         end else begin
            c.value = $signed(QUO_W'(-l.quo));
            c.sat   = 1'b0;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/cau_front.sv =====
// cau_front: three front pipeline stages (products, sums, scaling and divider setup)
// depends on cau_pkg
module cau_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  cau_pkg::cmd_type               in_cmd,
   input  logic signed [15:0]             in_a_real,
   input  logic signed [15:0]             in_a_imag,
   input  logic signed [15:0]             in_b_real,
   input  logic signed [15:0]             in_b_imag,
   output logic                           out_valid,
   output cau_pkg::pipe_word_type         out_word
);

   localparam int PW = cau_pkg::PART_W;
   localparam int WW = cau_pkg::WIDE_W;
   localparam int DW = cau_pkg::DEN_W;

   // stage 1 registers
   logic                   s1_valid_ff;
   cau_pkg::cmd_type       s1_cmd_ff;
   logic signed [DW-1:0]   p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, sq_r_ff, sq_i_ff;
   logic signed [PW:0]     sum_r_ff, sum_i_ff;
   logic signed [PW:0]     sum_r_in, sum_i_in;

   // stage 2 registers
   logic                   s2_valid_ff;
   cau_pkg::cmd_type       s2_cmd_ff;
   logic signed [WW-1:0]   mul_r_ff, mul_i_ff, num_r_ff, num_i_ff;
   logic [DW-1:0]          den_ff;
   logic signed [PW:0]     s2_sum_r_ff, s2_sum_i_ff;

   // stage 3 register
   logic                   s3_valid_ff;
   cau_pkg::pipe_word_type word_ff, word_in;

   // add or subtract picked in stage 1
   always_comb begin
      if (in_cmd == cau_pkg::CMD_SUB) begin
         sum_r_in = (PW+1)'(in_a_real) - (PW+1)'(in_b_real);
         sum_i_in = (PW+1)'(in_a_imag) - (PW+1)'(in_b_imag);
      end else begin
         sum_r_in = (PW+1)'(in_a_real) + (PW+1)'(in_b_real);
         sum_i_in = (PW+1)'(in_a_imag) + (PW+1)'(in_b_imag);
      end
   end

   // stage 3 word: scaling, saturation and divider setup
   always_comb begin
      cau_pkg::clip_type cr, ci;
      logic signed [WW-1:0] sr, si;
      sr = mul_r_ff >>> cau_pkg::FRAC_BITS;
      si = mul_i_ff >>> cau_pkg::FRAC_BITS;
      if (s2_cmd_ff == cau_pkg::CMD_MUL) begin
         cr = cau_pkg::clip_part(sr);
         ci = cau_pkg::clip_part(si);
      end else begin
         cr = cau_pkg::clip_part(WW'(s2_sum_r_ff));
         ci = cau_pkg::clip_part(WW'(s2_sum_i_ff));
      end
      word_in.is_div   = (s2_cmd_ff == cau_pkg::CMD_DIV);
      word_in.den_zero = (den_ff == '0);
      word_in.den      = den_ff;
      word_in.lane_r   = cau_pkg::lane_start(num_r_ff, den_ff);
      word_in.lane_i   = cau_pkg::lane_start(num_i_ff, den_ff);
      word_in.pre_real = cr.value;
      word_in.pre_imag = ci.value;
      word_in.pre_sat  = cr.sat | ci.sat;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff   <= in_cmd;
         p_rr_ff     <= DW'(in_a_real) * DW'(in_b_real);
         p_ii_ff     <= DW'(in_a_imag) * DW'(in_b_imag);
         p_ri_ff     <= DW'(in_a_real) * DW'(in_b_imag);
         p_ir_ff     <= DW'(in_a_imag) * DW'(in_b_real);
         sq_r_ff     <= DW'(in_b_real) * DW'(in_b_real);
         sq_i_ff     <= DW'(in_b_imag) * DW'(in_b_imag);
         sum_r_ff    <= sum_r_in;
         sum_i_ff    <= sum_i_in;
         s2_cmd_ff   <= s1_cmd_ff;
         mul_r_ff    <= WW'(p_rr_ff) - WW'(p_ii_ff);
         mul_i_ff    <= WW'(p_ri_ff) + WW'(p_ir_ff);
         num_r_ff    <= WW'(p_rr_ff) + WW'(p_ii_ff);
         num_i_ff    <= WW'(p_ir_ff) - WW'(p_ri_ff);
         den_ff      <= DW'(sq_r_ff) + DW'(sq_i_ff);
         s2_sum_r_ff <= sum_r_ff;
         s2_sum_i_ff <= sum_i_ff;
         word_ff     <= word_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_word  = word_ff;

endmodule

// ===== rtl/cau_div_step.sv =====
// cau_div_step: one restoring divider stage, one quotient bit for both lanes
// depends on cau_pkg
module cau_div_step #(
   parameter int BIT = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  cau_pkg::pipe_word_type in_word,
   output logic                   out_valid,
   output cau_pkg::pipe_word_type out_word
);

   localparam int CW = cau_pkg::CMP_W;
   localparam int NW = cau_pkg::NUM_W;

   logic                   valid_ff;
   cau_pkg::pipe_word_type word_ff, word_in;
   logic [CW-1:0]          trial;

   assign trial = CW'(in_word.den) << BIT;

   // compare and subtract the shifted divisor in each lane
   always_comb begin
      word_in = in_word;
      if (CW'(in_word.lane_r.rem) >= trial) begin
         word_in.lane_r.rem      = NW'(CW'(in_word.lane_r.rem) - trial);
         word_in.lane_r.quo[BIT] = 1'b1;
      end
      if (CW'(in_word.lane_i.rem) >= trial) begin
         word_in.lane_i.rem      = NW'(CW'(in_word.lane_i.rem) - trial);
         word_in.lane_i.quo[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ===== rtl/cau_back.sv =====
// cau_back: final stage, sign and saturation of quotients, result selection, output register
// depends on cau_pkg
module cau_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  cau_pkg::pipe_word_type in_word,
   output logic                   out_valid,
   output logic signed [15:0]     out_real,
   output logic signed [15:0]     out_imag,
   output cau_pkg::status_type    out_status
);

   logic                       valid_ff;
   logic signed [15:0]         real_ff, real_in;
   logic signed [15:0]         imag_ff, imag_in;
   cau_pkg::status_type        status_ff, status_in;

   // pick the result of the operation
   always_comb begin
      cau_pkg::clip_type cr, ci;
      cr = cau_pkg::lane_finish(in_word.lane_r);
      ci = cau_pkg::lane_finish(in_word.lane_i);
      if (in_word.is_div && in_word.den_zero) begin
         real_in   = '0;
         imag_in   = '0;
         status_in = cau_pkg::ST_DIVZ;
      end else if (in_word.is_div) begin
         real_in   = cr.value;
         imag_in   = ci.value;
         status_in = (cr.sat | ci.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end else begin
         real_in   = in_word.pre_real;
         imag_in   = in_word.pre_imag;
         status_in = in_word.pre_sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         real_ff   <= real_in;
         imag_ff   <= imag_in;
         status_ff <= status_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_real   = real_ff;
   assign out_imag   = imag_ff;
   assign out_status = status_ff;

endmodule

// ===== rtl/complex_arith_unit_core.sv =====
// complex_arith_unit_core: top level of the pipelined complex add/sub/mul/div unit
// depends on cau_pkg, cau_front, cau_div_step, cau_back
//
// usage
// - request channel: req_valid with req_command and the four Q8.8 operand parts;
//   a word is taken at a clock edge where req_valid is high and req_stall low
// - response channel: rsp_valid with rsp_res_real, rsp_res_imag and rsp_status;
//   the receiver holds rsp_stall high to keep the word in place
// - every operation runs through the same pipeline: three front stages
//   (products, sums, scaling), sixteen divider stages of one quotient bit each,
//   and one output stage
// - throughput is one word per cycle while rsp_stall does not hold the pipeline; results leave in order
// - when a response is waiting and rsp_stall is high, the whole pipeline holds
//   and req_stall goes high in the same cycle; no word is lost or repeated
// - synchronous reset empties the pipeline; the unit keeps no other state
// - status: ok, saturated (a part was clipped), or divide by zero (zero parts)
module complex_arith_unit_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [15:0] req_a_real,
   input  logic signed [15:0] req_a_imag,
   input  logic signed [15:0] req_b_real,
   input  logic signed [15:0] req_b_imag,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_res_real,
   output logic signed [15:0] rsp_res_imag,
   output logic [1:0]         rsp_status
);

   localparam int STEPS = cau_pkg::DIV_STEPS;

   logic                   adv;
   logic [STEPS:0]         valid_chain;
   cau_pkg::pipe_word_type word_chain [STEPS+1];
   cau_pkg::status_type    status;

   // pipeline moves unless a finished word is held by the receiver
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // front stages
   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_cmd    (cau_pkg::cmd_type'(req_command)),
      .in_a_real (req_a_real),
      .in_a_imag (req_a_imag),
      .in_b_real (req_b_real),
      .in_b_imag (req_b_imag),
      .out_valid (valid_chain[0]),
      .out_word  (word_chain[0])
   );

   // divider stages, most significant quotient bit first
   for (genvar k = 0; k < STEPS; k++) begin : g_div
      cau_div_step #(
         .BIT (STEPS - 1 - k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (valid_chain[k]),
         .in_word   (word_chain[k]),
         .out_valid (valid_chain[k+1]),
         .out_word  (word_chain[k+1])
      );
   end

   // output stage
   cau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (valid_chain[STEPS]),
      .in_word    (word_chain[STEPS]),
      .out_valid  (rsp_valid),
      .out_real   (rsp_res_real),
      .out_imag   (rsp_res_imag),
      .out_status (status)
   );

   assign rsp_status = status;

   // divide by zero gives zero parts
   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status == cau_pkg::ST_DIVZ) |-> (rsp_res_real == '0 && rsp_res_imag == '0))
      else $error("divide by zero response with nonzero parts");

   // saturated status means a part sits at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status == cau_pkg::ST_SAT) |->
         (rsp_res_real == cau_pkg::PART_MAX || rsp_res_real == cau_pkg::PART_MIN ||
          rsp_res_imag == cau_pkg::PART_MAX || rsp_res_imag == cau_pkg::PART_MIN))
      else $error("saturated status without a clipped part");

   // a stalled pipeline keeps its occupancy
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(valid_chain))
      else $error("pipeline moved while stalled");

endmodule

// ===== verif/complex_arith_unit_core_test.sv =====
// complex_arith_unit_core_test: self-checking testbench of the complex add/sub/mul/div unit
// depends on cau_pkg and complex_arith_unit_core; predicts each response from the request word
module complex_arith_unit_core_test;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_command;
   logic signed [15:0] req_a_real;
   logic signed [15:0] req_a_imag;
   logic signed [15:0] req_b_real;
   logic signed [15:0] req_b_imag;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_res_real;
   logic signed [15:0] rsp_res_imag;
   logic [1:0]         rsp_status;

   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic [1:0]         st;
   } answer_type;

   answer_type answer_fifo[$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  idle_on;
   bit  hold_rsp = 1'b0;
   event hold_kick;

   complex_arith_unit_core DUT (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("complex_arith_unit_core regression: fail");
         $finish;
      end
   end

   // saturate a wide value to one part
   function automatic logic signed [15:0] saturate(input longint x, inout bit sat);
      if (x > 32767) begin
         sat = 1'b1;
         return 16'sh7FFF;
      end
      if (x < -32768) begin
         sat = 1'b1;
         return 16'sh8000;
      end
      return x[15:0];
   endfunction

   // expected response of one request word
   function automatic answer_type complex_result(input cau_pkg::cmd_type c, input longint ar,
         input longint ai, input longint br, input longint bi);
      answer_type r;
      longint rr, ri, den;
      bit sat;
      sat = 1'b0;
      case (c)
         cau_pkg::CMD_ADD: begin
            rr = ar + br;
            ri = ai + bi;
         end
         cau_pkg::CMD_SUB: begin
            rr = ar - br;
            ri = ai - bi;
         end
         cau_pkg::CMD_MUL: begin
            rr = (ar * br - ai * bi) >>> cau_pkg::FRAC_BITS;
            ri = (ar * bi + br * ai) >>> cau_pkg::FRAC_BITS;
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.re = '0;
               r.im = '0;
               r.st = cau_pkg::ST_DIVZ;
               return r;
            end
            // signed division truncates toward zero
            rr = ((ar * br + ai * bi) * 256) / den;
            ri = ((ai * br - ar * bi) * 256) / den;
         end
      endcase
      r.re = saturate(rr, sat);
      r.im = saturate(ri, sat);
      r.st = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      return r;
   endfunction

   // long receiver hold-off, counted in cycles
   initial begin
      forever begin
         @(hold_kick);
         hold_rsp = 1'b1;
         repeat (60) @(posedge clock);
         hold_rsp = 1'b0;
      end
   end

   // response stall: random bursts, or held by the long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp)
            rsp_stall <= 1'b1;
         else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else
            rsp_stall <= 1'b0;
      end
   end

   // response checker
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answer_fifo.size() == 0) begin
            $display("%0t: unexpected word re=%0d im=%0d st=%0d", $time,
                     rsp_res_real, rsp_res_imag, rsp_status);
            error_count++;
         end else begin
            e = answer_fifo.pop_front();
            if (rsp_res_real !== e.re) begin
               $display("%0t: res_real expected %0d actual %0d", $time, e.re, rsp_res_real);
               error_count++;
            end
            if (rsp_res_imag !== e.im) begin
               $display("%0t: res_imag expected %0d actual %0d", $time, e.im, rsp_res_imag);
               error_count++;
            end
            if (rsp_status !== e.st) begin
               $display("%0t: status expected %0d actual %0d", $time, e.st, rsp_status);
               error_count++;
            end
         end
      end
   end

   // send one word, with an optional random gap before it
   task automatic send_word(input cau_pkg::cmd_type c, input logic [15:0] ar,
                            input logic [15:0] ai, input logic [15:0] br,
                            input logic [15:0] bi);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= c;
      req_a_real  <= ar;
      req_a_imag  <= ai;
      req_b_real  <= br;
      req_b_imag  <= bi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      answer_fifo.push_back(complex_result(c, $signed(ar), $signed(ai),
                                           $signed(br), $signed(bi)));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (answer_fifo.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_part;
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 3) - 2);
         3: return 16'($urandom_range(0, 1023) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // extremes, every command, zero divisor, saturation and rounding cases
   task automatic test_directed;
      cau_pkg::cmd_type c;
      for (int k = 0; k < 4; k++) begin
         c = cau_pkg::cmd_type'(k);
         send_word(c, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
         send_word(c, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
         send_word(c, 16'h0100, 16'hFF00, 16'h0200, 16'h0001);
         send_word(c, 16'hFFFF, 16'h0003, 16'h0001, 16'hFFFF);
         send_word(c, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      end
      send_word(cau_pkg::CMD_DIV, 16'h1234, 16'hFEDC, 16'h0000, 16'h0000);
      send_word(cau_pkg::CMD_DIV, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0001);
      send_word(cau_pkg::CMD_DIV, 16'hFFFF, 16'h0000, 16'h0003, 16'h0000);
      send_word(cau_pkg::CMD_MUL, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000);
      drain();
   endtask

   // random words, with random gaps on both sides while idle_on is set
   task automatic test_random(input int n);
      for (int k = 0; k < n; k++)
         send_word(cau_pkg::cmd_type'($urandom_range(0, 3)), rand_part(), rand_part(),
                   rand_part(), rand_part());
   endtask

   // receiver holds off long enough for the pipeline to fill and stall the sender
   task automatic test_backpressure;
      -> hold_kick;
      test_random(40);
      drain();
   endtask

   initial begin
      idle_on     = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = cau_pkg::CMD_ADD;
      req_a_real  = '0;
      req_a_imag  = '0;
      req_b_real  = '0;
      req_b_imag  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;
      test_directed();
      test_random(250);
      drain();
      test_backpressure();
      idle_on = 1'b0;
      test_random(100);
      drain();
      repeat (30) @(posedge clock);
      if (error_count == 0 && answer_fifo.size() == 0)
         $display("complex_arith_unit_core regression: pass");
      else
         $display("complex_arith_unit_core regression: fail");
      $finish;
   end

endmodule
